[rtl/core/e2c_pkg.sv]
// Shared types, constants and the month-length table for the epoch-seconds-to-calendar block.
// Depends on nothing; every other file in rtl/core imports it.

package e2c_pkg;

   localparam int DIV_WIDTH  = 32;
   localparam int DIVR_WIDTH = 17;
   localparam int CNT_WIDTH  = 6;

   localparam logic [DIVR_WIDTH-1:0] SECS_PER_DAY = 17'd86400;
   localparam logic [DIVR_WIDTH-1:0] CYCLE_DAYS   = 17'd1461;
   localparam logic [DIVR_WIDTH-1:0] SIXTY        = 17'd60;
   localparam logic [DIVR_WIDTH-1:0] WEEK_DAYS    = 17'd7;
   localparam logic [DIVR_WIDTH-1:0] YEAR_DAYS    = 17'd365;

   localparam logic [10:0] LEAP_DAY_IN_CYCLE = 11'd789;
   localparam logic [11:0] BASE_YEAR         = 12'd1970;
   localparam logic [15:0] WEEKDAY_BIAS      = 16'd4;
   localparam logic [10:0] ZONE_RESET        = 11'd480;
   localparam logic [3:0]  LAST_MONTH_IDX    = 4'd11;

   typedef struct packed {
      logic [31:0] epoch_seconds;
      logic        to_local;
   } req_type;

   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [2:0]  weekday;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_WIDTH-1:0]  dividend;
      logic [DIVR_WIDTH-1:0] divisor;
      logic [CNT_WIDTH-1:0]  count;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIV_WIDTH-1:0]  quotient;
      logic [DIVR_WIDTH-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic       start;
      logic [8:0] day;
   } mon_req_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      logic [3:0] month;
      logic [4:0] day_of_month;
   } mon_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DAYS,
      ST_CYCLE,
      ST_SECOND,
      ST_MINUTE,
      ST_WEEKDAY,
      ST_YEAR,
      ST_MONTH,
      ST_DONE
   } state_type;

   // Length of a month in a common year, January at index 0.
   function automatic logic [4:0] month_len(input logic [3:0] idx);
      logic [4:0] len;
      unique case (idx)
         4'd1:                         len = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:      len = 5'd30;
         default:                      len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[rtl/core/e2c_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, dividend left-aligned.
// Depends on e2c_pkg.

module e2c_div (
   input  logic                 clock,
   input  logic                 reset,
   input  e2c_pkg::div_req_type div_req,
   output e2c_pkg::div_rsp_type div_rsp
);
   import e2c_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [DIV_WIDTH-1:0]  quo_ff, quo_in;
   logic [DIVR_WIDTH-1:0] rem_ff, rem_in;
   logic [DIVR_WIDTH-1:0] dvs_ff, dvs_in;
   logic [DIVR_WIDTH:0]   trial;
   logic                  qbit;
   logic [DIVR_WIDTH:0]   diff;

   // The partial remainder stays below the divisor, so one shifted-in bit
   // keeps the trial value below twice the divisor.
   assign trial = {rem_ff, quo_ff[DIV_WIDTH-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign qbit  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.count;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[DIVR_WIDTH-1:0] : trial[DIVR_WIDTH-1:0];
         quo_in = {quo_ff[DIV_WIDTH-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[rtl/core/e2c_month.sv]
// Month walk: subtracts one month length per cycle from the day of the year.
// Depends on e2c_pkg for the month-length table and the port types.

module e2c_month (
   input  logic                 clock,
   input  logic                 reset,
   input  e2c_pkg::mon_req_type mon_req,
   output e2c_pkg::mon_rsp_type mon_rsp
);
   import e2c_pkg::*;

   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [3:0] idx_ff, idx_in;
   logic [8:0] rem_ff, rem_in;
   logic [8:0] len;

   assign len = {4'b0, month_len(idx_ff)};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      rem_in  = rem_ff;
      if (mon_req.start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         rem_in  = mon_req.day;
      end else if (busy_ff) begin
         if (idx_ff < LAST_MONTH_IDX && rem_ff >= len) begin
            rem_in = rem_ff - len;
            idx_in = idx_ff + 1'b1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff <= idx_in;
      rem_ff <= rem_in;
   end

   assign mon_rsp.busy         = busy_ff;
   assign mon_rsp.done         = done_ff;
   assign mon_rsp.month        = idx_ff + 1'b1;
   assign mon_rsp.day_of_month = rem_ff[4:0] + 1'b1;

endmodule

[rtl/core/epoch_seconds_to_calendar_top.sv]
// Top level of the epoch-seconds-to-calendar converter: sequencer, zone register, result register.
// Depends on e2c_pkg, e2c_div and e2c_month.

// The block turns a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into
// second, minute, hour, weekday (Sunday is 0), year, month and day of month.
// When a request beat has to_local set, the zone offset in minutes (written
// through the csr_ port, 480 after reset) is multiplied by 60 and added to
// the count first, with the sum wrapping to 32 bits. Every fourth year is
// taken as a leap year, so dates are exact through 2099. One request is
// worked on at a time, and the next request beat can be taken in the cycle
// in which the result beat is presented. The conversion runs on a single
// shared bit-serial divider that retires one quotient bit per cycle over
// six divisions in turn (32, 16, 17, 11, 16 and 11 bits), followed by a
// month walk; for a February 29 the last division and the month walk are
// skipped. The finished result waits in an output register, so the next
// request is taken while a result beat is still waiting for rsp_ready.
// The user must write the zone register only while the block is idle;
// the block itself does not enforce it.

module epoch_seconds_to_calendar_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  e2c_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output e2c_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [10:0]      csr_data
);
   import e2c_pkg::*;

   state_type   state_ff, state_in;
   div_req_type div_req;
   div_rsp_type div_rsp;
   mon_req_type mon_req;
   mon_rsp_type mon_rsp;

   logic [10:0] zone_ff;
   logic [31:0] zone_ext;
   logic [31:0] zone_secs;
   logic [31:0] secs;

   // Working values of the conversion in flight.
   logic [15:0] days_ff;
   logic [16:0] tod_ff;
   logic [5:0]  cycles_ff;
   logic [10:0] dic_ff;
   logic [10:0] dic_adj;
   logic        leap_day;
   logic [11:0] year_base;
   rsp_type     res_ff;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic        out_free;

   // Offset times 60 as (x << 6) - (x << 2); everything wraps to 32 bits.
   assign zone_ext  = {{21{zone_ff[10]}}, zone_ff};
   assign zone_secs = (zone_ext << 6) - (zone_ext << 2);
   assign secs      = req_data.epoch_seconds + (req_data.to_local ? zone_secs : 32'd0);

   // The leap day sits at day 789 of each four-year cycle; later days
   // shift down by one so that each year counts 365 days.
   assign leap_day  = (dic_ff == LEAP_DAY_IN_CYCLE);
   assign dic_adj   = (dic_ff > LEAP_DAY_IN_CYCLE) ? dic_ff - 11'd1 : dic_ff;
   assign year_base = BASE_YEAR + {4'b0, cycles_ff, 2'b00};

   assign out_free  = !rsp_valid_ff || rsp_ready;

   e2c_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   e2c_month u_month (
      .clock   (clock),
      .reset   (reset),
      .mon_req (mon_req),
      .mon_rsp (mon_rsp)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_DAYS;
         ST_DAYS:    if (div_rsp.done) state_in = ST_CYCLE;
         ST_CYCLE:   if (div_rsp.done) state_in = ST_SECOND;
         ST_SECOND:  if (div_rsp.done) state_in = ST_MINUTE;
         ST_MINUTE:  if (div_rsp.done) state_in = ST_WEEKDAY;
         ST_WEEKDAY: begin
            if (div_rsp.done) state_in = leap_day ? ST_DONE : ST_YEAR;
         end
         ST_YEAR:    if (div_rsp.done) state_in = ST_MONTH;
         ST_MONTH:   if (mon_rsp.done) state_in = ST_DONE;
         ST_DONE:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs: the divider is started with each dividend left-aligned in
   // 32 bits and a step count equal to its width.
   always_comb begin
      req_ready        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = SECS_PER_DAY;
      div_req.count    = CNT_WIDTH'(32);
      mon_req.start    = 1'b0;
      mon_req.day      = div_rsp.remainder[8:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready        = 1'b1;
            div_req.start    = req_valid;
            div_req.dividend = secs;
         end
         ST_DAYS: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = {div_rsp.quotient[15:0], 16'b0};
            div_req.divisor  = CYCLE_DAYS;
            div_req.count    = CNT_WIDTH'(16);
         end
         ST_CYCLE: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = {tod_ff, 15'b0};
            div_req.divisor  = SIXTY;
            div_req.count    = CNT_WIDTH'(17);
         end
         ST_SECOND: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = {div_rsp.quotient[10:0], 21'b0};
            div_req.divisor  = SIXTY;
            div_req.count    = CNT_WIDTH'(11);
         end
         ST_MINUTE: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = {days_ff + WEEKDAY_BIAS, 16'b0};
            div_req.divisor  = WEEK_DAYS;
            div_req.count    = CNT_WIDTH'(16);
         end
         ST_WEEKDAY: begin
            div_req.start    = div_rsp.done && !leap_day;
            div_req.dividend = {dic_adj, 21'b0};
            div_req.divisor  = YEAR_DAYS;
            div_req.count    = CNT_WIDTH'(11);
         end
         ST_YEAR: begin
            mon_req.start = div_rsp.done;
         end
         ST_MONTH, ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Collect the fields as each division and the month walk finish.
   always_ff @(posedge clock) begin
      if (div_rsp.done) begin
         unique case (state_ff)
            ST_DAYS: begin
               days_ff <= div_rsp.quotient[15:0];
               tod_ff  <= div_rsp.remainder;
            end
            ST_CYCLE: begin
               cycles_ff <= div_rsp.quotient[5:0];
               dic_ff    <= div_rsp.remainder[10:0];
            end
            ST_SECOND: res_ff.second <= div_rsp.remainder[5:0];
            ST_MINUTE: begin
               res_ff.minute <= div_rsp.remainder[5:0];
               res_ff.hour   <= div_rsp.quotient[4:0];
            end
            ST_WEEKDAY: begin
               res_ff.weekday <= div_rsp.remainder[2:0];
               if (leap_day) begin
                  res_ff.year         <= year_base + 12'd2;
                  res_ff.month        <= 4'd2;
                  res_ff.day_of_month <= 5'd29;
               end
            end
            ST_YEAR: res_ff.year <= year_base + {10'b0, div_rsp.quotient[1:0]};
            default: begin
            end
         endcase
      end
      if (mon_rsp.done) begin
         res_ff.month        <= mon_rsp.month;
         res_ff.day_of_month <= mon_rsp.day_of_month;
      end
   end

   // Result register and zone register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         zone_ff      <= ZONE_RESET;
      end else begin
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            zone_ff <= csr_data;
         end
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // The shared divider is never restarted while it is still stepping.
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy || div_rsp.done)
      else $error("divider started while busy");

   // No unit is left running when the sequencer goes back to idle.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_rsp.busy && !mon_rsp.busy)
      else $error("unit busy while sequencer idle");

   // The month walk always ends on a month from 1 to 12.
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      mon_rsp.done |-> mon_rsp.month >= 4'd1 && mon_rsp.month <= 4'd12)
      else $error("month out of range");

   // A result only appears after the sequencer has finished an item.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the done step");

endmodule

[test/tb_epoch_seconds_to_calendar_top.sv]
// Self-checking testbench for epoch_seconds_to_calendar_top: directed table plus random beats.
// Depends on e2c_pkg for request and response types and on epoch_seconds_to_calendar_top.

module tb_epoch_seconds_to_calendar_top;
   timeunit 1ns;
   timeprecision 1ps;

   import e2c_pkg::req_type;
   import e2c_pkg::rsp_type;

   // Calendar constants used by the date predictor below.
   localparam int unsigned DAY_SECONDS    = 86400;
   localparam int unsigned FOUR_YEAR_DAYS = 1461;
   localparam int unsigned LEAP_DAY       = 789;
   localparam int unsigned YEAR_DAYS      = 365;
   localparam int unsigned EPOCH_YEAR     = 1970;
   localparam int unsigned LAST_CYCLE     = 33;   // last four-year cycle holding a leap day
   localparam int unsigned COMMON_MONTH_DAYS [12] =
      '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   // Reset value of the zone register, in minutes.
   localparam logic [10:0] ZONE_AFTER_RESET = 11'd480;

   // Run shape: six random segments, each under its own zone offset.
   localparam int SEGMENTS       = 6;
   localparam int SEGMENT_BEATS  = 255;
   localparam int SETTLE_CYCLES  = 150;   // a little over one conversion
   localparam int STALL_LIMIT    = 5000;  // cycles without any handshake

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [10:0] csr_data = '0;

   // One directed row: a request and, where it is obvious, the date typed in by hand.
   typedef struct {
      req_type rq;
      bit      typed;
      rsp_type want;
   } date_case_type;

   date_case_type calendar_cases [$];
   rsp_type     pending_dates [$];    // predicted dates, oldest first
   logic [10:0] zone_minutes = ZONE_AFTER_RESET;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int n_sent       = 0;
   int n_local      = 0;
   int n_typed      = 0;
   int n_checked    = 0;
   int n_errors     = 0;
   int n_zones      = 0;
   int idle_cycles  = 0;

   epoch_seconds_to_calendar_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Works out the calendar date of one request under the given zone offset. The
   // offset is sign-extended from 11 bits, scaled to seconds and added with 32-bit
   // wraparound. The year comes from four-year cycles with the leap day at cycle
   // day 789, so every fourth year, 2100 included, gets a February 29.
   function automatic rsp_type predict_calendar(input req_type rq, input logic [10:0] zone);
      logic [31:0] secs;
      logic [31:0] days;
      logic [31:0] tod;
      logic [31:0] cycles;
      logic [31:0] dic;
      logic [31:0] year_num;
      int unsigned mon;
      int unsigned mday;
      rsp_type     r;
      secs = rq.epoch_seconds;
      if (rq.to_local) begin
         secs = secs + {{21{zone[10]}}, zone} * 32'd60;
      end
      days   = secs / DAY_SECONDS;
      tod    = secs % DAY_SECONDS;
      cycles = days / FOUR_YEAR_DAYS;
      dic    = days % FOUR_YEAR_DAYS;
      if (dic == LEAP_DAY) begin
         year_num = cycles * 4 + 2 + EPOCH_YEAR;
         mon      = 2;
         mday     = 29;
      end else begin
         // Days after the leap day slide back by one so that every year is 365 long.
         if (dic > LEAP_DAY) begin
            dic = dic - 1;
         end
         year_num = cycles * 4 + dic / YEAR_DAYS + EPOCH_YEAR;
         dic      = dic % YEAR_DAYS;
         mon      = 0;
         while (mon < 11 && dic >= COMMON_MONTH_DAYS[mon]) begin
            dic = dic - COMMON_MONTH_DAYS[mon];
            mon++;
         end
         mon  = mon + 1;
         mday = dic + 1;
      end
      r.second       = 6'(tod % 60);
      r.minute       = 6'((tod / 60) % 60);
      r.hour         = 5'(tod / 3600);
      r.weekday      = 3'((days + 4) % 7);
      r.year         = 12'(year_num);
      r.month        = 4'(mon);
      r.day_of_month = 5'(mday);
      return r;
   endfunction

   // Random request. Four beats in ten are plain random counts; the rest are steered onto
   // leap days, year starts, midnight edges, both ends of the range and single bits.
   function automatic req_type random_request();
      req_type     rq;
      longint      day_num;
      logic [31:0] small_count;
      logic [31:0] one_bit;
      int unsigned year_starts [4] = '{0, 365, 730, 1096};
      rq.to_local = 1'($urandom_range(1));
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            rq.epoch_seconds = $urandom();
         end
         4, 5: begin
            day_num = longint'($urandom_range(LAST_CYCLE)) * FOUR_YEAR_DAYS + LEAP_DAY
                      + longint'($urandom_range(4)) - 2;
            rq.epoch_seconds = 32'(day_num * DAY_SECONDS
                                   + longint'($urandom_range(DAY_SECONDS - 1)));
         end
         6: begin
            day_num = longint'($urandom_range(LAST_CYCLE)) * FOUR_YEAR_DAYS
                      + longint'(year_starts[$urandom_range(3)])
                      + longint'($urandom_range(2));
            day_num = (day_num == 0) ? 0 : day_num - 1;
            rq.epoch_seconds = 32'(day_num * DAY_SECONDS
                                   + longint'($urandom_range(1) ? DAY_SECONDS - 1 : 0));
         end
         7: begin
            // Midnight edges of a random day catch month boundaries.
            day_num = longint'($urandom_range(49709));
            rq.epoch_seconds = 32'(day_num * DAY_SECONDS
                                   + longint'($urandom_range(1) ? DAY_SECONDS - 1 : 0));
         end
         8: begin
            small_count = 32'($urandom_range(200000));
            rq.epoch_seconds = $urandom_range(1) ? small_count : ~small_count;
         end
         default: begin
            one_bit = 32'd1 << $urandom_range(31);
            rq.epoch_seconds = $urandom_range(1) ? one_bit : ~one_bit;
         end
      endcase
      return rq;
   endfunction

   task automatic add_case(input logic [31:0] secs, input logic loc, input bit typed = 1'b0,
                           input int s = 0, input int m = 0, input int h = 0,
                           input int wd = 0, input int y = 0, input int mo = 0,
                           input int d = 0);
      date_case_type c;
      c.rq.epoch_seconds   = secs;
      c.rq.to_local        = loc;
      c.typed              = typed;
      c.want.second        = 6'(s);
      c.want.minute        = 6'(m);
      c.want.hour          = 5'(h);
      c.want.weekday       = 3'(wd);
      c.want.year          = 12'(y);
      c.want.month         = 4'(mo);
      c.want.day_of_month  = 5'(d);
      calendar_cases.push_back(c);
   endtask

   // Presents one request beat, after an optional random gap, and records the
   // expected date once the beat is taken. Valid is only lowered when a gap is
   // chosen, so back-to-back beats keep it high without a glitch.
   task automatic send_request(input req_type rq, input bit typed, input rsp_type want);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3) == 0 ? $urandom_range(1, 140) : $urandom_range(1, 4))
            @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_dates.push_back(typed ? want : predict_calendar(rq, zone_minutes));
      n_sent++;
      n_local += rq.to_local;
      n_typed += typed;
   endtask

   task automatic wait_for_dates();
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   // The zone register is only written while the converter has nothing in flight.
   task automatic write_zone(input logic [10:0] minutes);
      csr_valid <= 1'b1;
      csr_data  <= minutes;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      zone_minutes  = minutes;
      n_zones++;
   endtask

   task automatic check_field(input string field_name, input int unsigned want_v,
                              input int unsigned got_v);
      if (want_v !== got_v) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field_name,
                  want_v, got_v);
      end
   endtask

   // Response side: stalls at random and compares every taken beat, field by
   // field, against the oldest predicted date. Values are sampled at the edge,
   // before the block's own registers move.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_dates.size() == 0) begin
               n_errors++;
               $display("%0t: response beat with nothing expected, got %0d-%0d-%0d",
                        $realtime, rsp_data.year, rsp_data.month, rsp_data.day_of_month);
            end else begin
               want = pending_dates.pop_front();
               n_checked++;
               check_field("second", want.second, rsp_data.second);
               check_field("minute", want.minute, rsp_data.minute);
               check_field("hour", want.hour, rsp_data.hour);
               check_field("weekday", want.weekday, rsp_data.weekday);
               check_field("year", want.year, rsp_data.year);
               check_field("month", want.month, rsp_data.month);
               check_field("day_of_month", want.day_of_month, rsp_data.day_of_month);
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog: any beat on any channel counts as progress.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d dates still expected", $realtime,
                     STALL_LIMIT, pending_dates.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int      zone_plan [SEGMENTS];
      rsp_type unused;
      unused    = '0;
      zone_plan = '{-720, 840, -1024, 1023, 0, 0};
      zone_plan[SEGMENTS-1] = int'($urandom_range(2047));

      // The directed rows run under the reset offset of +8 hours. Typed-in rows are
      // the epoch itself, the top of the counter (which wraps when made local), and
      // the leap days of 1972 and of 2100.
      add_case(32'd0,          1'b0, 1'b1,  0,  0, 0, 4, 1970, 1,  1);
      add_case(32'd0,          1'b1, 1'b1,  0,  0, 8, 4, 1970, 1,  1);
      add_case(32'hFFFF_FFFF,  1'b0, 1'b1, 15, 28, 6, 0, 2106, 2,  6);
      add_case(32'hFFFF_FFFF,  1'b1, 1'b1, 59, 59, 7, 4, 1970, 1,  1);
      add_case(32'd68169600,   1'b0, 1'b1,  0,  0, 0, 2, 1972, 2, 29);
      add_case(32'd4107542400, 1'b0, 1'b1,  0,  0, 0, 1, 2100, 2, 29);
      // The rest go through the predictor: day and year edges around the leap day,
      // midnight crossings made by the offset, and alternating bit patterns.
      add_case(32'd86399, 1'b0);
      add_case(32'd86399, 1'b1);
      add_case(32'd68169599, 1'b0);
      add_case(32'd68169599, 1'b1);
      add_case(32'd68256000, 1'b0);
      add_case(32'd94607999, 1'b0);
      add_case(32'd126143999, 1'b1);
      add_case(32'd126230400, 1'b0);
      add_case(32'd4107628800, 1'b1);
      add_case(32'h8000_0000, 1'b1);
      add_case(32'h7FFF_FFFF, 1'b0);
      add_case(32'hAAAA_AAAA, 1'b1);
      add_case(32'h5555_5555, 1'b0);

      req_idle_pct = 13;
      rsp_idle_pct = 73;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (calendar_cases[i]) begin
         send_request(calendar_cases[i].rq, calendar_cases[i].typed, calendar_cases[i].want);
      end

      // Random segments. The first third of the run starves the response side,
      // the next third the request side, and the last third runs flat out.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         req_valid <= 1'b0;
         wait_for_dates();
         if (seg < 2) begin
            req_idle_pct = 13;
            rsp_idle_pct = 73;
         end else if (seg < 4) begin
            req_idle_pct = 73;
            rsp_idle_pct = 13;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         write_zone(11'(zone_plan[seg]));
         repeat (SEGMENT_BEATS) send_request(random_request(), 1'b0, unused);
      end
      req_valid <= 1'b0;

      // Drain, then give a stray extra beat time to show up.
      wait_for_dates();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_dates.size() != 0) begin
         n_errors++;
         $display("%0t: %0d dates never came back", $realtime, pending_dates.size());
      end

      $display("tb: %0d conversions (%0d local, %0d hand-checked) under %0d zone offsets",
               n_sent, n_local, n_typed, n_zones + 1);
      $display("tb: %0d response beats compared, %0d field errors", n_checked, n_errors);
      if (n_errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
